// ----- src/ffha_pkg.sv -----
// Shared constants, types and state codes of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

   localparam int HEAP_BYTES   = 1048576;
   localparam int ALIGN_BYTES  = 8;
   localparam int HEADER_BYTES = 24;
   localparam int MAX_SEGMENTS = 64;

   localparam int ADDR_W  = 20;
   localparam int SIZE_W  = 21;
   localparam int IDX_W   = $clog2(MAX_SEGMENTS);
   localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int NEED_W  = SIZE_W + 2;

   localparam logic [SIZE_W-1:0] HEAP_INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
   localparam logic [ADDR_W-1:0] HDR_ADDR       = ADDR_W'(HEADER_BYTES);
   localparam logic [NEED_W-1:0] HDR_NEED       = NEED_W'(HEADER_BYTES);
   localparam logic [SIZE_W:0]   ALIGN_ADD      = (SIZE_W + 1)'(ALIGN_BYTES - 1);
   localparam logic [SIZE_W:0]   ALIGN_MASK     = ~((SIZE_W + 1)'(ALIGN_BYTES - 1));
   localparam logic [COUNT_W-1:0] COUNT_FULL    = COUNT_W'(MAX_SEGMENTS);

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_NULL_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } seg_type;

   localparam int SEG_W = $bits(seg_type);

   typedef enum logic [10:0] {
      S_INIT   = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_ASCAN  = 11'b000_0000_0100,
      S_ASHIFT = 11'b000_0000_1000,
      S_FFIND  = 11'b000_0001_0000,
      S_FSHIFT = 11'b000_0010_0000,
      S_FINS   = 11'b000_0100_0000,
      S_MSTART = 11'b000_1000_0000,
      S_MLOAD  = 11'b001_0000_0000,
      S_MRUN   = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

endpackage
`default_nettype wire

// ----- src/ffha_if.sv -----
// Request and response channel interfaces of the first-fit heap allocator.
`default_nettype none
interface ffha_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [20:0]                 request_bytes;
   logic [19:0]                 free_address;
   logic [20:0]                 free_size;
   modport source (output valid, opcode, request_bytes, free_address, free_size,
                   input ready);
   modport sink   (input valid, opcode, request_bytes, free_address, free_size,
                   output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [19:0] grant_address;
   logic [20:0] grant_size;
   modport source (output valid, status, grant_address, grant_size, input ready);
   modport sink   (input valid, status, grant_address, grant_size, output ready);
endinterface
`default_nettype wire

// ----- src/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator with its segment table sequencer.
//
// The allocator keeps the free space of a fixed heap as an address-ordered table of
// segments (header offset and payload size) in a 64-entry RAM, walked one entry per
// cycle by a small sequencer around compare and add datapaths. After reset the block
// writes the initial whole-heap segment in its INIT state before it takes its first
// request. An allocate request scans the table from the lowest address, and a
// whole-segment grant then moves the later entries down one by one. A free request
// scans for its place, moves the later entries up one by one, inserts, then sweeps
// the whole table once to merge neighbours. The block takes one request at a time; a
// finished response sits in an output register so that the next request may be taken
// while it waits to be read.
`default_nettype none
module first_fit_heap_allocator (
   input wire logic clock,
   input wire logic reset,
   ffha_req_if.sink   req_chan,
   ffha_rsp_if.source rsp_chan
);
   import ffha_pkg::*;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    wr_ff, wr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0]   asize_ff, asize_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [ADDR_W-1:0]   hdr_ff, hdr_in;
   logic [SIZE_W-1:0]   fsize_ff, fsize_in;
   seg_type             acc_ff, acc_in;
   status_type          res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [SIZE_W-1:0]   res_size_ff, res_size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   seg_type             ram_wdata;
   logic [SEG_W-1:0]    ram_rdata;
   seg_type             rd_seg;

   logic                flush_ff, flush_in;
   logic                ram_we_mux;
   logic [IDX_W-1:0]    ram_waddr_mux;
   seg_type             ram_wdata_mux;

   logic [COUNT_W-1:0]  idx_inc;
   logic                more;
   logic [SIZE_W:0]     req_round;
   logic [NEED_W-1:0]   req_need;
   logic [NEED_W-1:0]   rd_size_ext;
   logic [SIZE_W+1:0]   acc_end;
   logic [SIZE_W+1:0]   merged;
   logic                can_merge;

   // Segment table storage; the read address is always the next index, so the
   // registered read data lines up with idx_ff.
   ffha_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we_mux),
      .wr_addr (ram_waddr_mux),
      .wr_data (ram_wdata_mux),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   assign rd_seg      = seg_type'(ram_rdata);
   assign idx_inc     = COUNT_W'(idx_ff) + COUNT_W'(1);
   assign more        = idx_inc < count_ff;
   assign req_round   = ({1'b0, req_chan.request_bytes} + ALIGN_ADD) & ALIGN_MASK;
   assign req_need    = NEED_W'(req_round) + HDR_NEED;
   assign rd_size_ext = NEED_W'(rd_seg.size);

   // The merge unit: where the running segment ends, and how big it would grow.
   assign acc_end   = (SIZE_W + 2)'(acc_ff.start) + (SIZE_W + 2)'(HEADER_BYTES)
                    + (SIZE_W + 2)'(acc_ff.size);
   assign merged    = (SIZE_W + 2)'(acc_ff.size) + (SIZE_W + 2)'(HEADER_BYTES)
                    + (SIZE_W + 2)'(rd_seg.size);
   assign can_merge = (acc_end == (SIZE_W + 2)'(rd_seg.start))
                    && (merged[SIZE_W+1:SIZE_W] == 2'b00);

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.grant_address = rsp_addr_ff;
   assign rsp_chan.grant_size    = rsp_size_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      asize_in      = asize_ff;
      need_in       = need_ff;
      hdr_in        = hdr_ff;
      fsize_in      = fsize_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = rd_seg;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            ram_we          = 1'b1;
            ram_waddr       = '0;
            ram_wdata.start = '0;
            ram_wdata.size  = HEAP_INIT_SIZE;
            count_in        = COUNT_W'(1);
            idx_in          = '0;
            state_in        = S_IDLE;
         end

         S_IDLE: begin
            idx_in = '0;
            if (req_chan.valid) begin
               asize_in      = req_round[SIZE_W-1:0];
               need_in       = req_need;
               hdr_in        = req_chan.free_address - HDR_ADDR;
               fsize_in      = req_chan.free_size;
               res_addr_in   = '0;
               res_size_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               if (opcode_type'(req_chan.opcode) == OP_ALLOC) begin
                  res_status_in = ST_NO_FIT;
                  if (req_chan.request_bytes != '0 && count_ff != '0) begin
                     state_in = S_ASCAN;
                  end
               end else if (req_chan.free_address == '0) begin
                  res_status_in = ST_NULL_FREE;
               end else if (count_ff >= COUNT_FULL) begin
                  res_status_in = ST_TABLE_FULL;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = S_FINS;
               end else begin
                  state_in = S_FFIND;
               end
            end
         end

         // First fit: split a larger segment, or hand over one of exactly the size; report no fit if none is found.
         S_ASCAN: begin
            if (rd_size_ext > need_ff) begin
               ram_we          = 1'b1;
               ram_wdata.start = rd_seg.start + need_ff[ADDR_W-1:0];
               ram_wdata.size  = rd_seg.size - need_ff[SIZE_W-1:0];
               res_status_in   = ST_OK;
               res_addr_in     = rd_seg.start + HDR_ADDR;
               res_size_in     = asize_ff;
               state_in        = S_DONE;
            end else if (rd_size_ext == need_ff) begin
               res_status_in = ST_OK;
               res_addr_in   = rd_seg.start + HDR_ADDR;
               res_size_in   = rd_seg.size;
               if (more) begin
                  idx_in   = idx_inc[IDX_W-1:0];
                  state_in = S_ASHIFT;
               end else begin
                  count_in = count_ff - COUNT_W'(1);
                  state_in = S_DONE;
               end
            end else if (more) begin
               idx_in = idx_inc[IDX_W-1:0];
            end else begin
               state_in = S_DONE;
            end
         end

         // Close the gap left by a whole grant, one entry per cycle.
         S_ASHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff - IDX_W'(1);
            if (more) begin
               idx_in = idx_inc[IDX_W-1:0];
            end else begin
               count_in = count_ff - COUNT_W'(1);
               state_in = S_DONE;
            end
         end

         // Find the first segment whose header lies above the freed block.
         S_FFIND: begin
            if (rd_seg.start <= hdr_ff) begin
               if (more) begin
                  idx_in = idx_inc[IDX_W-1:0];
               end else begin
                  pos_in   = count_ff[IDX_W-1:0];
                  state_in = S_FINS;
               end
            end else begin
               pos_in   = idx_ff;
               idx_in   = count_ff[IDX_W-1:0] - IDX_W'(1);
               state_in = S_FSHIFT;
            end
         end

         // Open a slot by moving entries up, from the top downwards.
         S_FSHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff + IDX_W'(1);
            if (idx_ff > pos_ff) begin
               idx_in = idx_ff - IDX_W'(1);
            end else begin
               state_in = S_FINS;
            end
         end

         S_FINS: begin
            ram_we          = 1'b1;
            ram_waddr       = pos_ff;
            ram_wdata.start = hdr_ff;
            ram_wdata.size  = fsize_ff;
            count_in        = count_ff + COUNT_W'(1);
            idx_in          = '0;
            state_in        = S_MSTART;
         end

         // Re-issue the read of entry zero after the insert has landed.
         S_MSTART: begin
            idx_in   = '0;
            state_in = S_MLOAD;
         end

         // A table of one segment has no neighbours to merge.
         S_MLOAD: begin
            acc_in = rd_seg;
            wr_in  = '0;
            idx_in = IDX_W'(1);
            if (count_ff == COUNT_W'(1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MRUN;
            end
         end

         // One pass that folds each segment into the running one where they touch.
         S_MRUN: begin
            if (can_merge) begin
               acc_in.size = merged[SIZE_W-1:0];
            end else begin
               ram_we    = 1'b1;
               ram_waddr = wr_ff;
               ram_wdata = acc_ff;
               wr_in     = wr_ff + IDX_W'(1);
               acc_in    = rd_seg;
            end
            if (more) begin
               idx_in = idx_inc[IDX_W-1:0];
            end else begin
               count_in = COUNT_W'(wr_in) + COUNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            idx_in = '0;
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_size_in   = res_size_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // The merge pass ends by writing back the running segment in the cycle after its last step.
   assign flush_in = (state_ff == S_MRUN) && !more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         flush_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         flush_ff     <= flush_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      wr_ff         <= wr_in;
      asize_ff      <= asize_in;
      need_ff       <= need_in;
      hdr_ff        <= hdr_in;
      fsize_ff      <= fsize_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
   end

   // Final write of the running segment, in the cycle after the pass; the DONE state
   // performs no other write, and the next request reads the table only later.
   logic [IDX_W-1:0] flush_addr_ff;
   seg_type          flush_seg_ff;
   always_ff @(posedge clock) begin
      flush_addr_ff <= wr_in;
      flush_seg_ff  <= acc_in;
   end

   assign ram_we_mux    = ram_we | flush_ff;
   assign ram_waddr_mux = flush_ff ? flush_addr_ff : ram_waddr;
   assign ram_wdata_mux = flush_ff ? flush_seg_ff : ram_wdata;

endmodule
`default_nettype wire

// ----- src/ffha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- src/ffha_checker.sv -----
// Port-level assertions of the first-fit heap allocator and their bind.
`default_nettype none
module ffha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  status,
   input wire logic [19:0] grant_address,
   input wire logic [20:0] grant_size
);
   import ffha_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
         && $stable(grant_address) && $stable(grant_size))
      else $error("response changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_OK) |-> grant_address == '0 && grant_size == '0)
      else $error("failed request carries a grant");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response out of reset");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .status        (rsp_chan.status),
   .grant_address (rsp_chan.grant_address),
   .grant_size    (rsp_chan.grant_size)
);
`default_nettype wire
